// ===== src/imu_fp_pkg.sv =====
package imu_fp_pkg;

	typedef logic [7:0] byte_t;
	typedef logic signed [15:0] sample_t;

	localparam int STORE_DEPTH = 17;
	localparam int FRAME_BYTES = STORE_DEPTH + 1;
	localparam int CNT_W = $clog2(STORE_DEPTH + 1);

	typedef logic [0:0] reg_index_t;

	localparam reg_index_t REG_SYNC = 1'b0;
	localparam reg_index_t REG_TYPE = 1'b1;

	localparam byte_t SYNC_RESET = 8'h55;
	localparam byte_t TYPE_RESET = 8'h61;

endpackage

// ===== src/imu_frame_parser.sv =====
// Serial frame parser for a combined IMU data frame.
// The input channel (in_valid, in_stall, rx_byte) carries one received byte
// per request. The parser hunts for the sync byte followed at once by the
// type byte, then collects 18 payload bytes and emits one output request
// with nine signed 16-bit little-endian values on the output channel
// (out_valid, out_stall and the nine value ports).
// A byte is taken into an input register, and the parse step runs between
// that register and the output register, so a byte can be accepted in every
// cycle while no stalled frame holds the output. The last byte of a frame
// waits in the input register, then joins the frame in the output register.
// Sync and type bytes are set through the write port (cfg_wr_en, cfg_index,
// cfg_data), and a new value is used at the next compare.
// Reset returns the parser to hunting, empties both registers and loads
// the default sync and type bytes.
// When the receiver stalls, the finished frame holds on the outputs and the
// input register keeps its byte; in_stall rises only while a byte waits
// behind a stalled frame.
module imu_frame_parser (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_wr_en,
	input  imu_fp_pkg::reg_index_t cfg_index,
	input  imu_fp_pkg::byte_t    cfg_data,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  imu_fp_pkg::byte_t    rx_byte,
	output logic                 out_valid,
	input  logic                 out_stall,
	output imu_fp_pkg::sample_t  accel_x,
	output imu_fp_pkg::sample_t  accel_y,
	output imu_fp_pkg::sample_t  accel_z,
	output imu_fp_pkg::sample_t  rate_x,
	output imu_fp_pkg::sample_t  rate_y,
	output imu_fp_pkg::sample_t  rate_z,
	output imu_fp_pkg::sample_t  roll_angle,
	output imu_fp_pkg::sample_t  pitch_angle,
	output imu_fp_pkg::sample_t  yaw_angle
);
	import imu_fp_pkg::*;

	typedef enum logic [1:0] {
		PH_HUNT,
		PH_SYNC,
		PH_PAYLOAD
	} phase_t;

	phase_t             phase_q;
	phase_t             phase_d;
	logic [CNT_W-1:0]   count_q;
	logic [CNT_W-1:0]   count_d;
	byte_t              sync_q;
	byte_t              type_q;
	logic               valid_s1;
	byte_t              byte_s1;
	byte_t              store_q [STORE_DEPTH];
	byte_t              frame [FRAME_BYTES];
	logic               store_we;
	logic               emit;
	logic               advance;
	logic               out_valid_q;
	sample_t            sample_q [FRAME_BYTES / 2];

	assign advance  = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !advance;

	always_comb begin
		phase_d  = phase_q;
		count_d  = count_q;
		store_we = 1'b0;
		emit     = 1'b0;
		case (phase_q)
			PH_SYNC: begin
				if (byte_s1 == type_q) begin
					phase_d = PH_PAYLOAD;
					count_d = '0;
				end else if (byte_s1 != sync_q) begin
					phase_d = PH_HUNT;
				end
			end
			PH_PAYLOAD: begin
				if (count_q < CNT_W'(STORE_DEPTH)) begin
					store_we = 1'b1;
					count_d  = count_q + CNT_W'(1);
				end else begin
					emit    = 1'b1;
					phase_d = PH_HUNT;
					count_d = '0;
				end
			end
			default: begin
				phase_d = (byte_s1 == sync_q) ? PH_SYNC : PH_HUNT;
			end
		endcase
	end

	always_comb begin
		for (int i = 0; i < STORE_DEPTH; i++) begin
			frame[i] = store_q[i];
		end
		frame[STORE_DEPTH] = byte_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_HUNT;
			count_q     <= '0;
			sync_q      <= SYNC_RESET;
			type_q      <= TYPE_RESET;
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				case (cfg_index)
					REG_SYNC: sync_q <= cfg_data;
					REG_TYPE: type_q <= cfg_data;
					default: ;
				endcase
			end
			if (!in_stall) begin
				valid_s1 <= in_valid;
			end
			if (advance) begin
				phase_q <= phase_d;
				count_q <= count_d;
			end
			if (advance && emit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			byte_s1 <= rx_byte;
		end
		if (advance && store_we) begin
			store_q[count_q] <= byte_s1;
		end
		if (advance && emit) begin
			for (int k = 0; k < FRAME_BYTES / 2; k++) begin
				sample_q[k] <= sample_t'({frame[2 * k + 1], frame[2 * k]});
			end
		end
	end

	assign out_valid   = out_valid_q;
	assign accel_x     = sample_q[0];
	assign accel_y     = sample_q[1];
	assign accel_z     = sample_q[2];
	assign rate_x      = sample_q[3];
	assign rate_y      = sample_q[4];
	assign rate_z      = sample_q[5];
	assign roll_angle  = sample_q[6];
	assign pitch_angle = sample_q[7];
	assign yaw_angle   = sample_q[8];

endmodule
